// ===== design/pli_pkg.sv =====
// Shared constants, codes and interface types for the piecewise linear interpolator.
package pli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 8;
  localparam int POS_W       = 16;
  localparam int LVL_W       = 16;
  localparam int ENTRY_W     = POS_W + LVL_W;
  localparam int CNT_W       = 9;

  // Divider geometry: dividend is the product magnitude, divisor the segment width
  localparam int NUM_W   = 32;
  localparam int DEN_W   = 16;
  localparam int STEP_W  = $clog2(NUM_W);

  // Item kinds carried on in_tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH  = 2'd2;

  // Configuration reset values
  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 9'd2;
  localparam logic [POS_W-1:0] CLAMP_LOW_RST   = 16'hB000;  // -5.0 in Q4.12
  localparam logic [POS_W-1:0] CLAMP_HIGH_RST  = 16'h5000;  // +5.0 in Q4.12

  // Level saturation limit
  localparam logic [LVL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_FETCH_END,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } seq_state_t;

  // Table port request
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ENTRY_W-1:0]  wdata;   // level in upper half, position in lower half
    logic [ADDR_W-1:0]   raddr;
  } tbl_req_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/piecewise_linear_interpolator_core.sv =====
// Top level of the piecewise linear interpolator: config registers, output register, units.
//
//  Channel  Ports                      Beat contents (lowest bits first)
//  in       in_tvalid/tready/tdata/tuser  tuser: operation; tdata: entry_index,
//                                         entry_position, entry_level, query_position
//  out      out_tvalid/tready/tdata    level, segment
//  cfg      cfg_we/cfg_index/cfg_data  0 point_count, 1 clamp_low, 2 clamp_high
//
// A load beat is written to the table as it is taken. A query keeps in_tready low through
// the scan of the entries (at most the breakpoint count in use), the fetch of both segment
// ends, the product and, when the segment has nonzero width, the one-bit-per-cycle divider;
// the single table read port and the divider set this span. A finished query waits in
// its last step while the output register is full and stalled; otherwise the register
// holds the beat while the next item is taken in. Reset clears control and config only.
module piecewise_linear_interpolator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [55:0]                      in_tdata,   // entry_index, entry_position,
                                                       // entry_level, query_position
  input  logic                             in_tuser,   // operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // level, segment
  input  logic                             cfg_we,
  input  logic [pli_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  logic [pli_pkg::CNT_W-1:0] point_count_r;
  logic [pli_pkg::POS_W-1:0] clamp_low_r;
  logic [pli_pkg::POS_W-1:0] clamp_high_r;
  logic [pli_pkg::CNT_W-1:0] count_eff;

  logic                      out_valid_r, out_valid_nxt;
  logic [23:0]               out_data_r, out_data_nxt;

  pli_pkg::tbl_req_t             tbl_req;
  logic [pli_pkg::ENTRY_W-1:0]   tbl_rdata;
  pli_pkg::div_req_t             div_req;
  pli_pkg::div_rsp_t             div_rsp;
  logic                          res_free;
  logic                          res_valid;
  logic [pli_pkg::LVL_W-1:0]     res_level;
  logic [pli_pkg::IDX_W-1:0]     res_seg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= pli_pkg::POINT_COUNT_RST;
      clamp_low_r   <= pli_pkg::CLAMP_LOW_RST;
      clamp_high_r  <= pli_pkg::CLAMP_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pli_pkg::CFG_POINT_COUNT: point_count_r <= cfg_data[pli_pkg::CNT_W-1:0];
        pli_pkg::CFG_CLAMP_LOW:   clamp_low_r   <= cfg_data;
        pli_pkg::CFG_CLAMP_HIGH:  clamp_high_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the breakpoint count within 2..TABLE_DEPTH
  always_comb begin
    if (point_count_r < pli_pkg::CNT_W'(2)) begin
      count_eff = pli_pkg::CNT_W'(2);
    end else if (point_count_r > pli_pkg::CNT_W'(pli_pkg::TABLE_DEPTH)) begin
      count_eff = pli_pkg::CNT_W'(pli_pkg::TABLE_DEPTH);
    end else begin
      count_eff = point_count_r;
    end
  end

  pli_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (tbl_rdata)
  );

  pli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pli_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[7:0]),
    .in_pos    (in_tdata[23:8]),
    .in_lvl    (in_tdata[39:24]),
    .in_qpos   (in_tdata[55:40]),
    .count_eff (count_eff),
    .clamp_lo  (clamp_low_r),
    .clamp_hi  (clamp_high_r),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_level (res_level),
    .res_seg   (res_seg)
  );

  // Output register: load a finished result when the slot is empty or draining
  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res_seg, res_level};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A query beat occupies the block on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == pli_pkg::OP_QUERY) |=> !in_tready)
    else $error("block ready right after taking a query");

  // Reported segment never points at the first breakpoint
  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] != '0))
    else $error("segment index zero on output");

  // Reported segment lies below the breakpoint count in use
  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ({1'b0, res_seg} < count_eff))
    else $error("segment index beyond breakpoints in use");

  // Divider finishes only while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> !in_tready)
    else $error("divider result with the sequencer idle");

endmodule

// ===== design/pli_table.sv =====
// Breakpoint table memory: one write port, one registered read port.
module pli_table (
  input  logic                       clk,
  input  pli_pkg::tbl_req_t          req,
  output logic [pli_pkg::ENTRY_W-1:0] rdata
);

  logic [pli_pkg::ENTRY_W-1:0] mem [pli_pkg::TABLE_DEPTH];
  logic [pli_pkg::ENTRY_W-1:0] rdata_r;

  // Write one entry per load beat
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pli_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pli_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pli_pkg::div_req_t req,
  output pli_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [pli_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [pli_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [pli_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [pli_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [pli_pkg::DEN_W:0]     trial;
  logic [pli_pkg::DEN_W:0]     diff;
  logic                        fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[pli_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[pli_pkg::DEN_W-1:0] : trial[pli_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[pli_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pli_pkg::STEP_W'(pli_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== design/pli_seq.sv =====
// Sequencer: table loads, and for queries the table scan, segment fetch, product and divide steps.
module pli_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  // input beat
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [pli_pkg::IDX_W-1:0]    in_idx,
  input  logic [pli_pkg::POS_W-1:0]    in_pos,
  input  logic [pli_pkg::LVL_W-1:0]    in_lvl,
  input  logic [pli_pkg::POS_W-1:0]    in_qpos,
  // configuration
  input  logic [pli_pkg::CNT_W-1:0]    count_eff,
  input  logic [pli_pkg::POS_W-1:0]    clamp_lo,
  input  logic [pli_pkg::POS_W-1:0]    clamp_hi,
  // table
  output pli_pkg::tbl_req_t            tbl_req,
  input  logic [pli_pkg::ENTRY_W-1:0]  tbl_rdata,
  // divider
  output pli_pkg::div_req_t            div_req,
  input  pli_pkg::div_rsp_t            div_rsp,
  // result
  input  logic                         res_free,
  output logic                         res_valid,
  output logic [pli_pkg::LVL_W-1:0]    res_level,
  output logic [pli_pkg::IDX_W-1:0]    res_seg
);

  localparam int DIFF_W = pli_pkg::POS_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = pli_pkg::NUM_W + 2;

  pli_pkg::seq_state_t state_r, state_nxt;

  logic [pli_pkg::ADDR_W-1:0] k_r, k_nxt;
  logic [pli_pkg::ADDR_W-1:0] seg_r, seg_nxt;
  logic signed [pli_pkg::POS_W-1:0] x_r, x_nxt;
  logic signed [pli_pkg::POS_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic [pli_pkg::LVL_W-1:0]  l0_r, l0_nxt, l1_r, l1_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [DIFF_W-1:0]   dx_r, dx_nxt;
  logic                       neg_r, neg_nxt;
  logic [pli_pkg::LVL_W-1:0]  res_r, res_nxt;

  logic signed [pli_pkg::POS_W-1:0] qpos, lo, hi, x_hi, x_cl;
  logic signed [pli_pkg::POS_W-1:0] rd_pos;
  logic [pli_pkg::LVL_W-1:0]        rd_lvl;
  logic [pli_pkg::ADDR_W-1:0]       k_last;
  logic                             hit;
  logic [pli_pkg::ADDR_W-1:0]       seg_pick;
  logic signed [DIFF_W-1:0]         dl, dxq, dx_w;
  logic signed [PROD_W-1:0]         prod_w;
  logic [PROD_W-1:0]                prod_mag;
  logic [DIFF_W-1:0]                dx_mag;
  logic signed [SUM_W-1:0]          quo_s, sum_w;
  logic                             accept;

  // Clamp the query: upper bound first, then lower bound
  assign qpos = in_qpos;
  assign lo   = clamp_lo;
  assign hi   = clamp_hi;
  assign x_hi = (qpos >= hi) ? hi : qpos;
  assign x_cl = (x_hi <= lo) ? lo : x_hi;

  // Table read data
  assign rd_pos = tbl_rdata[pli_pkg::POS_W-1:0];
  assign rd_lvl = tbl_rdata[pli_pkg::ENTRY_W-1:pli_pkg::POS_W];

  // Scan compare and segment pick, held to 1..count-1
  assign k_last   = pli_pkg::ADDR_W'(count_eff - 1'b1);
  assign hit      = (rd_pos >= x_r);
  assign seg_pick = hit ? k_r : k_last;

  // Segment arithmetic
  assign dl       = $signed({1'b0, l1_r}) - $signed({1'b0, l0_r});
  assign dxq      = {x_r[pli_pkg::POS_W-1], x_r} - {p0_r[pli_pkg::POS_W-1], p0_r};
  assign dx_w     = {p1_r[pli_pkg::POS_W-1], p1_r} - {p0_r[pli_pkg::POS_W-1], p0_r};
  assign prod_w   = dl * dxq;
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : prod_r;
  assign dx_mag   = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : dx_r;

  // Signed quotient and final sum
  assign quo_s = neg_r ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
  assign sum_w = $signed({{(SUM_W - pli_pkg::LVL_W){1'b0}}, l0_r}) + quo_s;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    seg_nxt   = seg_r;
    x_nxt     = x_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    l0_nxt    = l0_r;
    l1_nxt    = l1_r;
    prod_nxt  = prod_r;
    dx_nxt    = dx_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    tbl_req.we    = 1'b0;
    tbl_req.waddr = in_idx[pli_pkg::ADDR_W-1:0];
    tbl_req.wdata = {in_lvl, in_pos};
    tbl_req.raddr = k_r;
    div_req.start = 1'b0;
    div_req.num   = prod_mag[pli_pkg::NUM_W-1:0];
    div_req.den   = dx_mag[pli_pkg::DEN_W-1:0];
    case (state_r)
      pli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_op == pli_pkg::OP_QUERY) begin
            x_nxt     = x_cl;
            k_nxt     = '0;
            state_nxt = pli_pkg::ST_SCAN_RD;
          end else begin
            tbl_req.we = 1'b1;
          end
        end
      end
      pli_pkg::ST_SCAN_RD: begin
        state_nxt = pli_pkg::ST_SCAN_CMP;
      end
      pli_pkg::ST_SCAN_CMP: begin
        if (hit || (k_r == k_last)) begin
          seg_nxt   = (seg_pick == '0) ? pli_pkg::ADDR_W'(1) : seg_pick;
          state_nxt = pli_pkg::ST_FETCH_LO;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = pli_pkg::ST_SCAN_RD;
        end
      end
      pli_pkg::ST_FETCH_LO: begin
        tbl_req.raddr = seg_r - 1'b1;
        state_nxt     = pli_pkg::ST_FETCH_HI;
      end
      pli_pkg::ST_FETCH_HI: begin
        tbl_req.raddr = seg_r;
        p0_nxt        = rd_pos;
        l0_nxt        = rd_lvl;
        state_nxt     = pli_pkg::ST_FETCH_END;
      end
      pli_pkg::ST_FETCH_END: begin
        p1_nxt    = rd_pos;
        l1_nxt    = rd_lvl;
        state_nxt = pli_pkg::ST_MUL;
      end
      pli_pkg::ST_MUL: begin
        prod_nxt  = prod_w;
        dx_nxt    = dx_w;
        state_nxt = pli_pkg::ST_DIV_GO;
      end
      pli_pkg::ST_DIV_GO: begin
        if (dx_r == '0) begin
          res_nxt   = l0_r;
          state_nxt = pli_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          neg_nxt       = prod_r[PROD_W-1] ^ dx_r[DIFF_W-1];
          state_nxt     = pli_pkg::ST_DIV_WAIT;
        end
      end
      pli_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (sum_w < 0) begin
            res_nxt = '0;
          end else if (sum_w > $signed({{(SUM_W - pli_pkg::LVL_W){1'b0}}, pli_pkg::LEVEL_MAX})) begin
            res_nxt = pli_pkg::LEVEL_MAX;
          end else begin
            res_nxt = sum_w[pli_pkg::LVL_W-1:0];
          end
          state_nxt = pli_pkg::ST_DONE;
        end
      end
      pli_pkg::ST_DONE: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pli_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    seg_r  <= seg_nxt;
    x_r    <= x_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    l0_r   <= l0_nxt;
    l1_r   <= l1_nxt;
    prod_r <= prod_nxt;
    dx_r   <= dx_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign res_level = res_r;
  assign res_seg   = pli_pkg::IDX_W'(seg_r);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the piecewise linear interpolator core.
`timescale 1ns / 100ps

module testbench;

  localparam int ITEM_TARGET  = 1000;
  localparam int CFG_SETTLE   = 8;       // loads are written as they are taken
  localparam int TAIL_CYCLES  = 600;     // longest query: full scan plus divider
  localparam int DRAIN_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;

  // One directed step: a/b carry position/level for loads, query position or register data
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  idx;
    logic [15:0] a;
    logic [15:0] b;
    logic        typed;
    logic [15:0] exp_level;
    logic [7:0]  exp_segment;
  } row_t;

  typedef struct packed {
    logic [7:0]  segment;
    logic [15:0] level;
  } result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [55:0]                   in_tdata;   // entry_index, entry_position, entry_level,
                                             // query_position
  logic                          in_tuser;   // operation
  logic                          out_tvalid;
  logic                          out_tready;
  logic [23:0]                   out_tdata;  // level, segment
  logic                          cfg_we;
  logic [pli_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  // Shadow of the breakpoint table and registers
  logic signed [15:0] bp_pos   [pli_pkg::TABLE_DEPTH];
  logic        [15:0] bp_level [pli_pkg::TABLE_DEPTH];
  logic        [8:0]  count_reg;
  logic signed [15:0] clamp_lo;
  logic signed [15:0] clamp_hi;

  result_t pending_levels [$];
  row_t    plan [$];

  int items_sent;
  int loads_sent;
  int queries_sent;
  int results_checked;
  int mismatches;
  int phases_run;
  int send_run;

  piecewise_linear_interpolator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #20000000;
    $display("Timeout: handshakes stopped before the end of the run");
    $display("Simulation FAILED");
    $finish;
  end

  // Wait length for one beat: mostly random, with bursts of back-to-back beats
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left = run_left - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = int'($urandom_range(8, 40));
      return 0;
    end
    return int'($urandom_range(0, 16));
  endfunction

  // Clamp, search the segment, interpolate with truncating division, saturate
  function automatic result_t interpolate_level(logic signed [15:0] qpos);
    result_t res;
    int      n, seg, k, x, lo, hi, p0, p1;
    longint  l0, l1, dx, prod, val;
    bit      found;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > pli_pkg::TABLE_DEPTH) n = pli_pkg::TABLE_DEPTH;
    x  = qpos;
    lo = clamp_lo;
    hi = clamp_hi;
    if (x >= hi) x = hi;
    if (x <= lo) x = lo;
    seg   = n - 1;
    found = 1'b0;
    for (k = 0; k < n; k++) begin
      p1 = bp_pos[k];
      if (!found && p1 >= x) begin
        seg   = k;
        found = 1'b1;
      end
    end
    if (seg < 1) seg = 1;
    p0 = bp_pos[seg-1];
    p1 = bp_pos[seg];
    l0 = bp_level[seg-1];
    l1 = bp_level[seg];
    dx = longint'(p1) - longint'(p0);
    if (dx == 0) begin
      val = l0;
    end else begin
      prod = (l1 - l0) * (longint'(x) - longint'(p0));
      val  = l0 + prod / dx;
    end
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    res.level   = val[15:0];
    res.segment = seg[7:0];
    return res;
  endfunction

  // Offer one beat after a random gap; on acceptance update the shadow or queue the result
  task automatic send_item(input logic op, input logic [7:0] idx, input logic [15:0] pos,
                           input logic [15:0] lvl, input logic [15:0] qpos,
                           input logic typed, input result_t typed_res);
    int gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {qpos, lvl, pos, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == pli_pkg::OP_LOAD) begin
      loads_sent++;
      bp_pos[idx]   = pos;
      bp_level[idx] = lvl;
    end else begin
      queries_sent++;
      if (typed) pending_levels.push_back(typed_res);
      else pending_levels.push_back(interpolate_level(qpos));
    end
  endtask

  // Drop valid and let the block go quiet before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pli_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pli_pkg::CFG_POINT_COUNT: count_reg = data[8:0];
      pli_pkg::CFG_CLAMP_LOW:   clamp_lo  = data;
      pli_pkg::CFG_CLAMP_HIGH:  clamp_hi  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Ascending breakpoints with random levels; some steps of zero width
  task automatic load_breakpoints(input int n);
    int step_max, pos, k;
    step_max = 65535 / n;
    pos = -32768 + int'($urandom_range(0, step_max));
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 7) != 0) pos = pos + int'($urandom_range(1, step_max));
      if (pos > 32767) pos = 32767;
      send_item(pli_pkg::OP_LOAD, k[7:0], pos[15:0], 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 1'b0, '0);
    end
  endtask

  // Result side: random stalls, two long hold-offs, compare each beat to the oldest entry
  initial begin : result_side
    int      stall;
    int      run;
    result_t want;
    result_t got;
    out_tready = 1'b0;
    run = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_checked == 60 || results_checked == 400) stall = LONG_HOLD;
      else stall = draw_wait(run);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = out_tdata;
      results_checked++;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result beat: level %h segment %0d", got.level, got.segment);
      end else begin
        want = pending_levels.pop_front();
        if (got.level !== want.level || got.segment !== want.segment) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Result %0d: expected level %h segment %0d, got level %h segment %0d",
                     results_checked, want.level, want.segment, got.level, got.segment);
        end
      end
    end
  end

  // Stimulus: directed walk, then random table phases, then drain and report
  initial begin : stimulus
    int          n, nq, i, k, sel, pa, pb, waited;
    logic [8:0]  count_val;
    logic [15:0] lo_val, hi_val, qp;
    row_t        r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = pli_pkg::OP_LOAD;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = pli_pkg::CFG_POINT_COUNT;
    cfg_data   = '0;
    count_reg  = pli_pkg::POINT_COUNT_RST;
    clamp_lo   = pli_pkg::CLAMP_LOW_RST;
    clamp_hi   = pli_pkg::CLAMP_HIGH_RST;
    items_sent = 0; loads_sent = 0; queries_sent = 0;
    results_checked = 0; mismatches = 0; phases_run = 0; send_run = 0;
    for (k = 0; k < pli_pkg::TABLE_DEPTH; k++) begin
      bp_pos[k]   = '0;
      bp_level[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two points at -1.0 and +1.0 under the reset bounds of +-5.0
    plan.push_back(row_t'{ROW_LOAD,  8'd0, 16'hF000, 16'h1000, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_LOAD,  8'd1, 16'h1000, 16'h3000, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h0000, 16'h0000, 1'b1, 16'h2000, 8'd1});
    // Clamped to -5.0 and extrapolated below zero: saturate low
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h8000, 16'h0000, 1'b1, 16'h0000, 8'd1});
    // Clamped to +5.0, past the last point: extrapolate upward
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h7FFF, 16'h0000, 1'b1, 16'h7000, 8'd1});
    // Widest bounds
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_LOW),  16'h8000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_HIGH), 16'h7FFF, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h7FFF, 16'h0000, 1'b1, 16'h9FFF, 8'd1});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h8000, 16'h0000, 1'b1, 16'h0000, 8'd1});
    // Crossed bounds: the low bound wins, lands on the upper point
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_LOW),  16'h1000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_HIGH), 16'hF000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h8000, 16'h0000, 1'b1, 16'h3000, 8'd1});
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_LOW),  16'hB000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_CLAMP_HIGH), 16'h5000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    // Steep rise past full scale: saturate high
    plan.push_back(row_t'{ROW_LOAD,  8'd1, 16'h1000, 16'hFFFF, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h5000, 16'h0000, 1'b1, 16'hFFFF, 8'd1});
    // Zero-width segment returns the lower level
    plan.push_back(row_t'{ROW_LOAD,  8'd1, 16'hF000, 16'hFFFF, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h0000, 16'h0000, 1'b1, 16'h1000, 8'd1});
    // Falling segment: negative quotient truncates toward zero
    plan.push_back(row_t'{ROW_LOAD,  8'd0, 16'h0000, 16'h0002, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_LOAD,  8'd1, 16'h0003, 16'h0000, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h0001, 16'h0000, 1'b1, 16'h0002, 8'd1});
    // Extreme entries, out of order
    plan.push_back(row_t'{ROW_LOAD,  8'd2, 16'h7FFF, 16'hFFFF, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_LOAD,  8'd3, 16'h8000, 16'h0000, 1'b0, 16'h0000, 8'd0});
    // Count of zero acts as two
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_POINT_COUNT), 16'h0000, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h0002, 16'h0000, 1'b1, 16'h0001, 8'd1});
    plan.push_back(row_t'{ROW_CFG, 8'(pli_pkg::CFG_POINT_COUNT), 16'h0004, 16'h0, 1'b0,
                          16'h0, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h4000, 16'h0000, 1'b0, 16'h0000, 8'd0});
    plan.push_back(row_t'{ROW_QUERY, 8'd0, 16'h8000, 16'h0000, 1'b0, 16'h0000, 8'd0});

    foreach (plan[j]) begin
      r = plan[j];
      case (r.kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(r.idx[pli_pkg::CFG_IDX_W-1:0], r.a);
        end
        ROW_LOAD:
          send_item(pli_pkg::OP_LOAD, r.idx, r.a, r.b, 16'($urandom_range(0, 65535)),
                    1'b0, '0);
        default:
          send_item(pli_pkg::OP_QUERY, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), r.a,
                    r.typed, {r.exp_segment, r.exp_level});
      endcase
    end

    // Random phases: new settings, a sorted table, then queries mixed with stray loads
    while (items_sent < ITEM_TARGET) begin
      phases_run++;
      if (phases_run == 3) begin
        n = pli_pkg::TABLE_DEPTH;
        count_val = 9'h1FF;
      end else if (phases_run == 6) begin
        n = int'($urandom_range(64, 160));
        count_val = n[8:0];
      end else begin
        n = ($urandom_range(0, 5) == 0) ? 2 : int'($urandom_range(2, 32));
        count_val = n[8:0];
        if (n == 2 && $urandom_range(0, 1) == 0) count_val = 9'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 7))
        0: begin
          lo_val = 16'h8000;
          hi_val = 16'h7FFF;
        end
        1: begin
          lo_val = 16'($urandom_range(0, 65535));
          hi_val = 16'($urandom_range(0, 65535));
        end
        default: begin
          pa = int'($urandom_range(0, 65535)) - 32768;
          pb = int'($urandom_range(0, 65535)) - 32768;
          if (pa > pb) begin
            k  = pa;
            pa = pb;
            pb = k;
          end
          lo_val = pa[15:0];
          hi_val = pb[15:0];
        end
      endcase
      wait_idle();
      write_reg(pli_pkg::CFG_POINT_COUNT, {7'd0, count_val});
      write_reg(pli_pkg::CFG_CLAMP_LOW, lo_val);
      write_reg(pli_pkg::CFG_CLAMP_HIGH, hi_val);
      load_breakpoints(n);

      nq = (n > 64) ? 12 : int'($urandom_range(15, 40));
      for (i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray load, may break the ordering of the in-use points
          k = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, n - 1))
                                          : int'($urandom_range(0, 255));
          send_item(pli_pkg::OP_LOAD, k[7:0], 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0, '0);
        end else begin
          sel = int'($urandom_range(0, 7));
          k   = int'($urandom_range(0, n - 1));
          if (sel < 2) begin
            qp = 16'($urandom_range(0, 65535));
          end else if (sel == 2) begin
            qp = bp_pos[k];
          end else if (sel == 3) begin
            qp = 16'(int'(bp_pos[k]) + int'($urandom_range(0, 2)) - 1);
          end else begin
            pa = bp_pos[0];
            pb = bp_pos[n-1];
            if (pa > pb) begin
              k  = pa;
              pa = pb;
              pb = k;
            end
            pa = pa + int'($urandom_range(0, pb - pa));
            qp = pa[15:0];
          end
          send_item(pli_pkg::OP_QUERY, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), qp,
                    1'b0, '0);
        end
      end
    end

    // Drain, then give the block time to emit anything stray
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0) begin
      $display("%0d expected results never arrived", pending_levels.size());
      mismatches += pending_levels.size();
    end

    $display("Ran %0d loads and %0d queries over %0d random table settings plus directed cases",
             loads_sent, queries_sent, phases_run);
    $display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
